FILE: src/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the double-double add/subtract pipeline.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int unsigned F64_W     = 64;
  // register stages in one binary64 adder
  localparam int unsigned ADD_LAT   = 3;
  // chained adder slots: two-sum (4), error sum, low words plus error,
  // fast two-sum (3)
  localparam int unsigned NUM_UNITS = 9;
  localparam int unsigned PIPE_DEPTH = ADD_LAT * NUM_UNITS;

  localparam logic [F64_W-1:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [F64_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

  // opcode values
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [F64_W-1:0] a_hi;
    logic [F64_W-1:0] a_lo;
    logic [F64_W-1:0] b_hi;
    logic [F64_W-1:0] b_lo;
  } in_beat_t;

  typedef struct packed {
    logic [F64_W-1:0] sum_hi;
    logic [F64_W-1:0] sum_lo;
  } out_beat_t;

  // intermediate values carried down the pipeline
  typedef struct packed {
    logic [F64_W-1:0] xh;
    logic [F64_W-1:0] yh;
    logic [F64_W-1:0] s;
    logic [F64_W-1:0] lo;
    logic [F64_W-1:0] xv;
    logic [F64_W-1:0] yv;
    logic [F64_W-1:0] dx;
    logic [F64_W-1:0] dy;
    logic [F64_W-1:0] e;
    logic [F64_W-1:0] t;
    logic [F64_W-1:0] hi;
    logic [F64_W-1:0] d;
  } ctx_t;

endpackage

FILE: src/double_double_add_sub_top.sv
// ----------------------------------------------------------------------------
// double_double_add_sub_top
// Double-double add/subtract: two-sum of the high words, low words plus
// error, then a fast two-sum renormalization, all on pipelined adders.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall  | opcode, a_hi, a_lo, b_hi, b_lo
//   out_    | output    | out_valid/out_stall| sum_hi, sum_lo
//
// One beat per cycle in and one result per cycle out while out_stall is low;
// the pipeline is nine dependent binary64 adds of three stages each.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse while the output is stalled.
// in_stall rises only when every stage holds a beat and out_stall is high.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module double_double_add_sub_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dda_pkg::in_beat_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dda_pkg::out_beat_t   out_data
);
  import dda_pkg::*;

  logic [PIPE_DEPTH-1:0] v_r, v_nxt, en;
  ctx_t                  ctx_r  [PIPE_DEPTH];
  ctx_t                  ctx_in [PIPE_DEPTH];
  logic [F64_W-1:0]      opa [NUM_UNITS];
  logic [F64_W-1:0]      opb [NUM_UNITS];
  logic [F64_W-1:0]      res [NUM_UNITS];
  logic [F64_W-1:0]      lo_res, dx_res, flip;

  // stage enables: ripple back from the output
  always_comb begin
    en[PIPE_DEPTH-1] = ~v_r[PIPE_DEPTH-1] | ~out_stall;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
    v_nxt = {v_r[PIPE_DEPTH-2:0], in_valid};
  end

  assign in_stall = ~en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  // context entering each stage, with unit results merged at boundaries
  always_comb begin
    flip = (in_data.opcode == OP_SUB) ? SIGN_BIT : '0;
    ctx_in[0]    = '0;
    ctx_in[0].xh = in_data.a_hi;
    ctx_in[0].yh = in_data.b_hi ^ flip;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      ctx_in[k] = ctx_r[k-1];
    end
    ctx_in[1*ADD_LAT].s  = res[0];
    ctx_in[1*ADD_LAT].lo = lo_res;
    ctx_in[2*ADD_LAT].xv = res[1];
    ctx_in[3*ADD_LAT].yv = res[2];
    ctx_in[3*ADD_LAT].dx = dx_res;
    ctx_in[4*ADD_LAT].dy = res[3];
    ctx_in[5*ADD_LAT].e  = res[4];
    ctx_in[6*ADD_LAT].t  = res[5];
    ctx_in[7*ADD_LAT].hi = res[6];
    ctx_in[8*ADD_LAT].d  = res[7];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (en[k]) ctx_r[k] <= ctx_in[k];
    end
  end

  // adder operands; a subtraction flips the sign of the second word
  always_comb begin
    opa[0] = ctx_in[0].xh;             opb[0] = ctx_in[0].yh;
    opa[1] = ctx_in[1*ADD_LAT].s;      opb[1] = ctx_in[1*ADD_LAT].yh ^ SIGN_BIT;
    opa[2] = ctx_in[2*ADD_LAT].s;      opb[2] = ctx_in[2*ADD_LAT].xv ^ SIGN_BIT;
    opa[3] = ctx_in[3*ADD_LAT].yh;     opb[3] = ctx_in[3*ADD_LAT].yv ^ SIGN_BIT;
    opa[4] = ctx_in[4*ADD_LAT].dx;     opb[4] = ctx_in[4*ADD_LAT].dy;
    opa[5] = ctx_in[5*ADD_LAT].lo;     opb[5] = ctx_in[5*ADD_LAT].e;
    opa[6] = ctx_in[6*ADD_LAT].s;      opb[6] = ctx_in[6*ADD_LAT].t;
    opa[7] = ctx_in[7*ADD_LAT].hi;     opb[7] = ctx_in[7*ADD_LAT].s ^ SIGN_BIT;
    opa[8] = ctx_in[8*ADD_LAT].t;      opb[8] = ctx_in[8*ADD_LAT].d ^ SIGN_BIT;
  end

  // chained adder slots
  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_unit
    dda_fadd u_add (
      .clk (clk),
      .en  (en[u*ADD_LAT +: ADD_LAT]),
      .a   (opa[u]),
      .b   (opb[u]),
      .y   (res[u])
    );
  end

  // low words, alongside the high-word sum
  dda_fadd u_add_lo (
    .clk (clk),
    .en  (en[0 +: ADD_LAT]),
    .a   (in_data.a_lo),
    .b   (in_data.b_lo ^ flip),
    .y   (lo_res)
  );

  // dx = xh - xv, alongside yv
  dda_fadd u_add_dx (
    .clk (clk),
    .en  (en[2*ADD_LAT +: ADD_LAT]),
    .a   (ctx_in[2*ADD_LAT].xh),
    .b   (ctx_in[2*ADD_LAT].xv ^ SIGN_BIT),
    .y   (dx_res)
  );

  // output beat
  assign out_valid       = v_r[PIPE_DEPTH-1];
  assign out_data.sum_hi = ctx_r[PIPE_DEPTH-1].hi;
  assign out_data.sum_lo = res[NUM_UNITS-1];

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_hi_qnan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (&out_data.sum_hi[62:52]) && (|out_data.sum_hi[51:0]))
      |-> (out_data.sum_hi == QNAN_BITS))
    else $error("non-canonical NaN in sum_hi");

  a_lo_qnan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (&out_data.sum_lo[62:52]) && (|out_data.sum_lo[51:0]))
      |-> (out_data.sum_lo == QNAN_BITS))
    else $error("non-canonical NaN in sum_lo");
`endif

endmodule

FILE: src/dda_fadd.sv
// ----------------------------------------------------------------------------
// dda_fadd
// Three-stage binary64 adder, round to nearest even, with subnormals,
// infinities and canonical NaN. Each stage has its own load enable.
// ----------------------------------------------------------------------------
module dda_fadd (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic [dda_pkg::F64_W-1:0] a,
  input  logic [dda_pkg::F64_W-1:0] b,
  output logic [dda_pkg::F64_W-1:0] y
);
  import dda_pkg::*;

  localparam logic [10:0] ALIGN_MAX = 11'd56;

  // ---------------- stage 1: classify, order, align ----------------
  logic         a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0]  big, sml;
  logic [10:0]  eff_big, eff_sml, diff;
  logic [52:0]  m_big, m_sml;
  logic [5:0]   sh;
  logic [108:0] shv;
  logic [55:0]  mb_al;
  logic [63:0]  spec_val;

  logic         s1_sign_r, s1_sub_r, s1_both_neg_r, s1_spec_r;
  logic [10:0]  s1_exp_r;
  logic [55:0]  s1_ma_r, s1_mb_r;
  logic [63:0]  s1_spec_val_r;

  always_comb begin
    a_nan   = (&a[62:52]) & (|a[51:0]);
    b_nan   = (&b[62:52]) & (|b[51:0]);
    a_inf   = (&a[62:52]) & ~(|a[51:0]);
    b_inf   = (&b[62:52]) & ~(|b[51:0]);
    swap    = b[62:0] > a[62:0];
    big     = swap ? b : a;
    sml     = swap ? a : b;
    eff_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    eff_sml = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    m_big   = {|big[62:52], big[51:0]};
    m_sml   = {|sml[62:52], sml[51:0]};
    diff    = eff_big - eff_sml;
    sh      = (diff > ALIGN_MAX) ? ALIGN_MAX[5:0] : diff[5:0];
    shv     = {m_sml, 56'd0} >> sh;
    // guard, round and sticky below the 53-bit significand
    mb_al   = {shv[108:54], shv[53] | (|shv[52:0])};
    if (a_nan || b_nan || (a_inf && b_inf && (a[63] ^ b[63]))) begin
      spec_val = QNAN_BITS;
    end else if (a_inf) begin
      spec_val = a;
    end else begin
      spec_val = b;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sign_r     <= big[63];
      s1_sub_r      <= a[63] ^ b[63];
      s1_both_neg_r <= a[63] & b[63];
      s1_spec_r     <= a_nan | b_nan | a_inf | b_inf;
      s1_spec_val_r <= spec_val;
      s1_exp_r      <= eff_big;
      s1_ma_r       <= {m_big, 3'b000};
      s1_mb_r       <= mb_al;
    end
  end

  // ---------------- stage 2: add, leading-zero count ----------------
  logic [56:0] sum;
  logic [5:0]  lz, lsh;
  logic [10:0] lim;

  logic        s2_sign_r, s2_both_neg_r, s2_spec_r, s2_zero_r, s2_right_r;
  logic [56:0] s2_sum_r;
  logic [5:0]  s2_lsh_r;
  logic [10:0] s2_exp_r;
  logic [63:0] s2_spec_val_r;

  always_comb begin
    sum = s1_sub_r ? ({1'b0, s1_ma_r} - {1'b0, s1_mb_r})
                   : ({1'b0, s1_ma_r} + {1'b0, s1_mb_r});
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (sum[i]) lz = 6'(55 - i);
    end
    // stop at the smallest normal exponent: below that the result is subnormal
    lim = s1_exp_r - 11'd1;
    lsh = ({5'd0, lz} > lim) ? lim[5:0] : lz;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_sign_r     <= s1_sign_r;
      s2_both_neg_r <= s1_both_neg_r;
      s2_spec_r     <= s1_spec_r;
      s2_spec_val_r <= s1_spec_val_r;
      s2_zero_r     <= (sum == 57'd0);
      s2_right_r    <= sum[56];
      s2_sum_r      <= sum;
      s2_lsh_r      <= lsh;
      s2_exp_r      <= sum[56] ? (s1_exp_r + 11'd1) : (s1_exp_r - {5'd0, lsh});
    end
  end

  // ---------------- stage 3: normalize, round, pack ----------------
  logic [55:0] rn;
  logic [10:0] ef;
  logic        inc, ovf;
  logic [63:0] pk, res;

  always_comb begin
    rn  = s2_right_r ? {s2_sum_r[56:2], s2_sum_r[1] | s2_sum_r[0]}
                     : (s2_sum_r[55:0] << s2_lsh_r);
    ef  = rn[55] ? s2_exp_r : 11'd0;
    inc = rn[2] & ((|rn[1:0]) | rn[3]);
    // a rounding carry steps the exponent field, subnormal to normal included
    pk  = {1'b0, ef, rn[54:3]} + {63'd0, inc};
    ovf = pk[63] | (&pk[62:52]);
    if (s2_spec_r) begin
      res = s2_spec_val_r;
    end else if (s2_zero_r) begin
      res = {s2_both_neg_r, 63'd0};
    end else if (ovf) begin
      res = {s2_sign_r, 11'h7FF, 52'd0};
    end else begin
      res = {s2_sign_r, pk[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y <= res;
    end
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-double add/subtract pipeline. Directed
// beats cover signed zeros, infinities, NaNs, overflow, subnormals and
// rounding ties. Random beats follow: mostly well-formed double-double pairs,
// plus raw bit patterns. Each result is compared with a binary64 predictor.
// ----------------------------------------------------------------------------
module tb;
  import dda_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = PIPE_DEPTH + 20;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  out_beat_t   sum_queue[$];
  int unsigned errors = 0;
  int unsigned beats_sent;
  int unsigned beats_checked = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle;

  double_double_add_sub_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // any NaN word comes out as the canonical quiet NaN
  function automatic logic [F64_W-1:0] canon_nan(real v);
    logic [F64_W-1:0] b;
    b = $realtobits(v);
    if (b[62:52] == 11'h7FF && b[51:0] != 52'd0) begin
      b = QNAN_BITS;
    end
    return b;
  endfunction

  // sloppy double-double sum; each real op rounds to nearest even
  function automatic out_beat_t dd_sum(in_beat_t b);
    logic [F64_W-1:0] flip;
    real xh, xl, yh, yl, s, xv, yv, dx, dy, e, lo, t, hi, d, r;
    out_beat_t res;
    flip = (b.opcode == OP_SUB) ? SIGN_BIT : '0;
    xh = $bitstoreal(b.a_hi);
    xl = $bitstoreal(b.a_lo);
    yh = $bitstoreal(b.b_hi ^ flip);
    yl = $bitstoreal(b.b_lo ^ flip);
    // two-sum of the high words
    s  = xh + yh;
    xv = s - yh;
    yv = s - xv;
    dx = xh - xv;
    dy = yh - yv;
    e  = dx + dy;
    // low words plus error
    lo = xl + yl;
    t  = lo + e;
    // fast two-sum
    hi = s + t;
    d  = hi - s;
    r  = t - d;
    res.sum_hi = canon_nan(hi);
    res.sum_lo = canon_nan(r);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [F64_W-1:0] got,
                                 logic [F64_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)",
             what, got, want, beats_checked);
    errors++;
  endtask

  // send one beat, with random idle cycles ahead of it
  task automatic send_beat(in_beat_t b);
    bit stalled;
    logic [9*32-1:0] junk;
    while (!no_idle && $urandom_range(99) < 23) begin
      junk = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      in_valid <= 1'b0;
      in_data  <= in_beat_t'(junk[$bits(in_beat_t)-1:0]);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sum_queue.push_back(dd_sum(b));
    beats_sent++;
  endtask

  // result side stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 23);
    end
  end

  // result check and watchdog; values are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", sum_queue.size());
        $display("simulation failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (sum_queue.size() == 0) begin
          report_mismatch("unexpected beat", out_data.sum_hi, '0);
        end else begin
          out_beat_t want;
          want = sum_queue.pop_front();
          if (out_data.sum_hi !== want.sum_hi) begin
            report_mismatch("sum_hi", out_data.sum_hi, want.sum_hi);
          end
          if (out_data.sum_lo !== want.sum_lo) begin
            report_mismatch("sum_lo", out_data.sum_lo, want.sum_lo);
          end
        end
        beats_checked++;
      end
    end
  end

  function automatic in_beat_t mk_beat(logic op, logic [63:0] ah, logic [63:0] al,
                                       logic [63:0] bh, logic [63:0] bl);
    in_beat_t b;
    b.opcode = op;
    b.a_hi   = ah;
    b.a_lo   = al;
    b.b_hi   = bh;
    b.b_lo   = bl;
    return b;
  endfunction

  // random binary64: raw bits, special values, or a chosen exponent
  function automatic logic [63:0] rand_f64(int unsigned exp_lo, int unsigned exp_hi);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'h000;
      2: v[62:0]  = '0;
      3: ;
      default: v[62:52] = 11'($urandom_range(exp_hi, exp_lo));
    endcase
    return v;
  endfunction

  // well-formed pair: low word about 2^-53 of the high word or less
  function automatic void rand_pair(output logic [63:0] hi, output logic [63:0] lo,
                                    input int unsigned exp_lo, input int unsigned exp_hi);
    int unsigned e;
    e  = $urandom_range(exp_hi, exp_lo);
    hi = {$urandom, $urandom};
    hi[62:52] = 11'(e);
    lo = {$urandom, $urandom};
    lo[62:52] = (e > 53 + 10) ? 11'(e - 53 - $urandom_range(10)) : 11'h000;
  endfunction

  task automatic test_directed();
    send_beat(mk_beat(OP_ADD, 64'h0, 64'h0, 64'h0, 64'h0));
    send_beat(mk_beat(OP_SUB, 64'h0, 64'h0, 64'h0, 64'h0));
    send_beat(mk_beat(OP_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
    send_beat(mk_beat(OP_ADD, 64'h7FF0_0000_0000_0000, 64'h0,
                      64'hFFF0_0000_0000_0000, 64'h0));
    send_beat(mk_beat(OP_SUB, 64'h7FF0_0000_0000_0000, 64'h0,
                      64'h7FF0_0000_0000_0000, 64'h0));
    send_beat(mk_beat(OP_ADD, 64'h7FF0_0000_0000_0000, 64'h0, 64'h3FF0_0000_0000_0000,
                      64'h0));
    // NaN payloads, quiet and signaling, on each word and negated
    send_beat(mk_beat(OP_ADD, 64'h7FF0_0000_0000_0001, 64'h0, 64'h3FF0_0000_0000_0000,
                      64'h0));
    send_beat(mk_beat(OP_SUB, 64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFF8_0000_0000_1234, 64'h7FF4_0000_0000_0000));
    // overflow of the high sum
    send_beat(mk_beat(OP_ADD, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7C9F_FFFF_FFFF_FFFF,
                      64'h7FEF_FFFF_FFFF_FFFF, 64'h7C9F_FFFF_FFFF_FFFF));
    send_beat(mk_beat(OP_SUB, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0,
                      64'h7FEF_FFFF_FFFF_FFFF, 64'h0));
    // subnormals
    send_beat(mk_beat(OP_ADD, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001,
                      64'h000F_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001));
    send_beat(mk_beat(OP_SUB, 64'h0010_0000_0000_0000, 64'h0,
                      64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003));
    // rounding ties: 1 + 2^-53 and 1 + 3*2^-53
    send_beat(mk_beat(OP_ADD, 64'h3FF0_0000_0000_0000, 64'h0,
                      64'h3CA0_0000_0000_0000, 64'h0));
    send_beat(mk_beat(OP_ADD, 64'h3FF0_0000_0000_0001, 64'h3C90_0000_0000_0000,
                      64'h3CA0_0000_0000_0000, 64'h3C90_0000_0000_0000));
    // exact cancellation and non-normalized operands
    send_beat(mk_beat(OP_SUB, 64'h4009_21FB_5444_2D18, 64'h3CA1_A626_3314_5C07,
                      64'h4009_21FB_5444_2D18, 64'h3CA1_A626_3314_5C07));
    send_beat(mk_beat(OP_ADD, 64'h3FF0_0000_0000_0000, 64'h4340_0000_0000_0000,
                      64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000));
    send_beat(mk_beat(OP_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  task automatic test_random(int unsigned count);
    in_beat_t b;
    logic [63:0] ah, al, bh, bl;
    for (int unsigned i = 0; i < count; i++) begin
      // an idle-free stretch in the middle
      no_idle = (i >= count / 3) && (i < count / 3 + 150);
      case ($urandom_range(9))
        0, 1: begin
          b = mk_beat(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        end
        2: begin
          b = mk_beat(1'($urandom), rand_f64(0, 2047), rand_f64(0, 2047),
                      rand_f64(0, 2047), rand_f64(0, 2047));
        end
        3: begin
          // near cancellation: b close to a
          rand_pair(ah, al, 900, 1150);
          bh = ah + 64'($urandom_range(4)) - 64'd2;
          rand_pair(bl, bl, 900, 1150);
          bl = {$urandom, $urandom};
          bl[62:52] = al[62:52];
          b = mk_beat(OP_SUB, ah, al, bh ^ (64'(ah[63] ^ bh[63]) << 63), bl);
          if ($urandom_range(1)) b.b_hi = ah;
        end
        4: begin
          // extreme exponents, near overflow or underflow
          rand_pair(ah, al, 2000, 2046);
          rand_pair(bh, bl, 2000, 2046);
          if ($urandom_range(1)) begin
            rand_pair(ah, al, 0, 60);
            rand_pair(bh, bl, 0, 60);
          end
          b = mk_beat(1'($urandom), ah, al, bh, bl);
        end
        default: begin
          rand_pair(ah, al, 900, 1150);
          rand_pair(bh, bl, 900, 1150);
          b = mk_beat(1'($urandom), ah, al, bh, bl);
        end
      endcase
      send_beat(b);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    beats_sent    = 0;
    no_idle       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(1000);
    // no more beats to send
    in_valid <= 1'b0;

    // drain
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats: signed zeros, infinities, NaNs, overflow, subnormals,",
             beats_sent);
    $display("ties, cancellation and random double-double pairs; %0d results checked",
             beats_checked);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/dda_pkg.sv
src/dda_fadd.sv
src/double_double_add_sub_top.sv
verif/tb.sv
